[src/cmd64_pkg.sv]
// ----------------------------------------------------------------------------
// cmd64_pkg
// Shared constants for the clamped multiply-divide block and its checker.
// ----------------------------------------------------------------------------
package cmd64_pkg;

    // width of the scaled result port
    localparam int OUT_W = 63;

    // multiplier pipeline depth (four partial products)
    localparam int MUL_STAGES = 4;

endpackage

[src/clamped_muldiv_64.sv]
// ----------------------------------------------------------------------------
// clamped_muldiv_64
// Pipelined floor(value * min(work, total) / total) for signed operands,
// zero when any operand is zero or negative.
// ----------------------------------------------------------------------------
// A new word is taken on every cycle that start is high; busy never rises.
// Each word gives exactly one result on o_scaled, flagged by o_valid for one
// cycle. The pipeline holds one clamp stage, four partial-product stages that
// build the full product from the operand halves, and one restoring-division
// stage per quotient bit (DATA_WIDTH - 1 of them). Results leave in order and
// the receiver has no way to hold them off.
// ----------------------------------------------------------------------------
module clamped_muldiv_64
    import cmd64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic signed [DATA_WIDTH-1:0] i_work,
    input  logic signed [DATA_WIDTH-1:0] i_total,
    output logic                         o_valid,
    output logic        [OUT_W-1:0]      o_scaled
);

    // magnitude width of a positive operand, multiplier split, product width
    localparam int AW = DATA_WIDTH - 1;
    localparam int ML = (AW + 1) / 2;
    localparam int MH = AW - ML;
    localparam int PW = 2 * AW;

    // ------------------------------------------------------------------
    // clamp stage
    // ------------------------------------------------------------------
    logic          w_take;
    logic          w_pos;
    logic [AW-1:0] w_val_m;
    logic [AW-1:0] w_wrk_m;
    logic [AW-1:0] w_tot_m;

    logic          r_c_vld;
    logic [AW-1:0] r_c_a;
    logic [AW-1:0] r_c_b;
    logic [AW-1:0] r_c_d;

    logic          n_c_vld;
    logic [AW-1:0] n_c_a;
    logic [AW-1:0] n_c_b;
    logic [AW-1:0] n_c_d;

    // the block never stalls
    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_val_m = i_value[AW-1:0];
    assign w_wrk_m = i_work[AW-1:0];
    assign w_tot_m = i_total[AW-1:0];

    // all three operands strictly positive
    assign w_pos = !i_value[AW] && (w_val_m != '0) &&
                   !i_work[AW]  && (w_wrk_m != '0) &&
                   !i_total[AW] && (w_tot_m != '0);

    // clamp work to total; zero product with unit divisor otherwise
    always_comb begin
        n_c_vld = w_take;
        if (w_pos) begin
            n_c_a = w_val_m;
            n_c_b = (w_wrk_m < w_tot_m) ? w_wrk_m : w_tot_m;
            n_c_d = w_tot_m;
        end else begin
            n_c_a = '0;
            n_c_b = '0;
            n_c_d = AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= n_c_vld;
        end
        r_c_a <= n_c_a;
        r_c_b <= n_c_b;
        r_c_d <= n_c_d;
    end

    // ------------------------------------------------------------------
    // multiplier: one partial product per stage, accumulated
    // ------------------------------------------------------------------
    logic [2*ML-1:0]  w_pp_ll;
    logic [ML+MH-1:0] w_pp_lh;
    logic [ML+MH-1:0] w_pp_hl;
    logic [2*MH-1:0]  w_pp_hh;

    logic          r_m_vld [MUL_STAGES];
    logic [AW-1:0] r_m_d   [MUL_STAGES];
    logic [PW-1:0] r_m_acc [MUL_STAGES];
    logic [AW-1:0] r_m_a   [MUL_STAGES-1];
    logic [AW-1:0] r_m_b   [MUL_STAGES-1];

    logic [PW-1:0] n_m_acc [MUL_STAGES];

    assign w_pp_ll = r_c_a[ML-1:0] * r_c_b[ML-1:0];
    assign w_pp_lh = r_m_a[0][ML-1:0] * r_m_b[0][AW-1:ML];
    assign w_pp_hl = r_m_a[1][AW-1:ML] * r_m_b[1][ML-1:0];
    assign w_pp_hh = r_m_a[2][AW-1:ML] * r_m_b[2][AW-1:ML];

    // accumulate shifted partial products
    always_comb begin
        n_m_acc[0] = PW'(w_pp_ll);
        n_m_acc[1] = r_m_acc[0] + (PW'(w_pp_lh) << ML);
        n_m_acc[2] = r_m_acc[1] + (PW'(w_pp_hl) << ML);
        n_m_acc[3] = r_m_acc[2] + (PW'(w_pp_hh) << (2 * ML));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MUL_STAGES; k++) begin
                r_m_vld[k] <= 1'b0;
            end
        end else begin
            r_m_vld[0] <= r_c_vld;
            for (int k = 1; k < MUL_STAGES; k++) begin
                r_m_vld[k] <= r_m_vld[k-1];
            end
        end
        r_m_d[0] <= r_c_d;
        r_m_a[0] <= r_c_a;
        r_m_b[0] <= r_c_b;
        for (int k = 1; k < MUL_STAGES; k++) begin
            r_m_d[k] <= r_m_d[k-1];
        end
        for (int k = 1; k < MUL_STAGES - 1; k++) begin
            r_m_a[k] <= r_m_a[k-1];
            r_m_b[k] <= r_m_b[k-1];
        end
        for (int k = 0; k < MUL_STAGES; k++) begin
            r_m_acc[k] <= n_m_acc[k];
        end
    end

    // ------------------------------------------------------------------
    // restoring divider: one quotient bit per stage
    // the product is below total * 2^AW, so its upper half starts below total
    // ------------------------------------------------------------------
    logic          r_dv_vld [AW];
    logic [AW-1:0] r_dv_rem [AW];
    logic [AW-1:0] r_dv_q   [AW];
    logic [AW-1:0] r_dv_d   [AW];

    logic [AW-1:0] n_dv_rem [AW];
    logic [AW-1:0] n_dv_q   [AW];

    genvar g;
    generate
        for (g = 0; g < AW; g++) begin : g_div
            logic          w_src_vld;
            logic [AW-1:0] w_src_rem;
            logic [AW-1:0] w_src_q;
            logic [AW-1:0] w_src_d;
            logic [AW:0]   w_ext;
            logic [AW+1:0] w_diff;
            logic          w_ge;

            if (g == 0) begin : g_first
                assign w_src_vld = r_m_vld[MUL_STAGES-1];
                assign w_src_rem = r_m_acc[MUL_STAGES-1][PW-1:AW];
                assign w_src_q   = r_m_acc[MUL_STAGES-1][AW-1:0];
                assign w_src_d   = r_m_d[MUL_STAGES-1];
            end else begin : g_next
                assign w_src_vld = r_dv_vld[g-1];
                assign w_src_rem = r_dv_rem[g-1];
                assign w_src_q   = r_dv_q[g-1];
                assign w_src_d   = r_dv_d[g-1];
            end

            // shift in the next dividend bit, trial subtract
            assign w_ext  = {w_src_rem, w_src_q[AW-1]};
            assign w_diff = {1'b0, w_ext} - {2'b00, w_src_d};
            assign w_ge   = !w_diff[AW+1];

            always_comb begin
                n_dv_rem[g] = w_ge ? w_diff[AW-1:0] : w_ext[AW-1:0];
                n_dv_q[g]   = {w_src_q[AW-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[g] <= 1'b0;
                end else begin
                    r_dv_vld[g] <= w_src_vld;
                end
                r_dv_rem[g] <= n_dv_rem[g];
                r_dv_q[g]   <= n_dv_q[g];
                r_dv_d[g]   <= w_src_d;
            end
        end
    endgenerate

    // result word
    assign o_valid  = r_dv_vld[AW-1];
    assign o_scaled = OUT_W'(r_dv_q[AW-1]);

endmodule

[src/cmd64_chk.sv]
// ----------------------------------------------------------------------------
// cmd64_chk
// Port-level checker for the clamped multiply-divide block, bound into the block.
// ----------------------------------------------------------------------------
module cmd64_chk
    import cmd64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [DATA_WIDTH-1:0] i_value,
    input logic signed [DATA_WIDTH-1:0] i_work,
    input logic signed [DATA_WIDTH-1:0] i_total,
    input logic                         o_valid,
    input logic        [OUT_W-1:0]      o_scaled
);

    localparam int LAT = DATA_WIDTH + 4;

    // never stalls
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every accepted word comes out on o_valid
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word did not come out");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    // result never exceeds the magnitude of value
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_scaled <= OUT_W'($past(i_value[DATA_WIDTH-2:0], LAT))))
        else $error("result above value");

    // non-positive total gives zero
    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_total[DATA_WIDTH-1] || (i_total == '0), LAT))
        |-> (o_scaled == '0))
        else $error("non-positive total gave nonzero result");

endmodule

bind clamped_muldiv_64 cmd64_chk #(.DATA_WIDTH(DATA_WIDTH)) u_cmd64_chk (.*);
